// ===== design/csem_pkg.sv =====
// Shared types and constants for the counting semaphore wait queue.
package csem_pkg;

   localparam int ID_W   = 4;
   localparam int PRIO_W = 5;
   localparam int CSR_W  = 16;
   localparam int FAULT_W = 2;

   localparam logic OP_TAKE = 1'b0;
   localparam logic OP_GIVE = 1'b1;

   localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_FULL = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_SAT  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture request word
      logic exec;   // apply request, load result registers
   } csem_cmd_type;

endpackage

// ===== design/counting_semaphore_wait_queue.sv =====
// Top level of the counting semaphore with a first-in first-out wait queue.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ---------------------------
//  request   req_op, req_task_id, req_task_priority  start high, busy low
//  result    rsp_blocked .. rsp_fault                rsp_valid, one cycle
//  config    csr_wdata                               csr_we, no wait
//
//  Each word is captured while the head waiter is read from the queue store
//  (registered read), then executed in the EXEC state; the result strobes in
//  the cycle after execution, while the next word may already be accepted.
//  Reset leaves a count of one and an empty queue; a config write reloads the
//  count and empties the queue. The receiver cannot stall results.
module counting_semaphore_wait_queue
   import csem_pkg::*;
#(
   parameter int MAX_TASKS       = 16,
   parameter int PRIORITY_LEVELS = 32,
   parameter int COUNT_BITS      = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [ID_W-1:0]    req_task_id,
   input  logic [PRIO_W-1:0]  req_task_priority,
   output logic               rsp_valid,
   output logic               rsp_blocked,
   output logic               rsp_woken_valid,
   output logic [ID_W-1:0]    rsp_woken_task,
   output logic [PRIO_W-1:0]  rsp_woken_priority,
   output logic               rsp_preempt,
   output logic [FAULT_W-1:0] rsp_fault,
   input  logic               csr_we,
   input  logic [CSR_W-1:0]   csr_wdata
);

   csem_cmd_type cmd;

   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   csem_dp #(
      .MAX_TASKS       (MAX_TASKS),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .COUNT_BITS      (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_task_id        (req_task_id),
      .req_task_priority  (req_task_priority),
      .rsp_blocked        (rsp_blocked),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_task     (rsp_woken_task),
      .rsp_woken_priority (rsp_woken_priority),
      .rsp_preempt        (rsp_preempt),
      .rsp_fault          (rsp_fault)
   );

endmodule

// ===== design/csem_ctrl.sv =====
// Sequencing state machine for the semaphore: accept, execute, strobe result.
module csem_ctrl
   import csem_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output csem_cmd_type cmd,
   output logic         rsp_valid
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy         = (state_ff == ST_EXEC);
   assign cmd.load     = start && !busy;
   assign cmd.exec     = busy;
   assign rsp_valid_in = cmd.exec;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/csem_dp.sv =====
// Semaphore datapath: token counter, circular wait queue and result registers.
module csem_dp
   import csem_pkg::*;
#(
   parameter int MAX_TASKS       = 16,
   parameter int PRIORITY_LEVELS = 32,
   parameter int COUNT_BITS      = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  csem_cmd_type       cmd,
   input  logic               csr_we,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               req_op,
   input  logic [ID_W-1:0]    req_task_id,
   input  logic [PRIO_W-1:0]  req_task_priority,
   output logic               rsp_blocked,
   output logic               rsp_woken_valid,
   output logic [ID_W-1:0]    rsp_woken_task,
   output logic [PRIO_W-1:0]  rsp_woken_priority,
   output logic               rsp_preempt,
   output logic [FAULT_W-1:0] rsp_fault
);

   localparam int PTR_W   = $clog2(MAX_TASKS);
   localparam int TOTAL_W = $clog2(MAX_TASKS + 1);
   localparam int ENTRY_W = ID_W + PRIO_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [PTR_W-1:0]      LAST_SLOT  = PTR_W'(MAX_TASKS - 1);
   localparam logic [TOTAL_W-1:0]    TOTAL_FULL = TOTAL_W'(MAX_TASKS);

   function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
      if (int'(p) > PRIORITY_LEVELS - 1)
         return PRIO_W'(PRIORITY_LEVELS - 1);
      return p;
   endfunction

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + PTR_W'(1);
   endfunction

   logic [ENTRY_W-1:0] mem [MAX_TASKS];
   logic [ENTRY_W-1:0] rd_ff;

   logic                  op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [PRIO_W-1:0]     prio_ff;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   logic                  blocked_ff, blocked_in;
   logic                  woken_ff, woken_in;
   logic [ID_W-1:0]       wtask_ff, wtask_in;
   logic [PRIO_W-1:0]     wprio_ff, wprio_in;
   logic                  preempt_ff, preempt_in;
   logic [FAULT_W-1:0]    fault_ff, fault_in;

   logic push_w, pop_w;
   logic [ID_W-1:0]   head_id;
   logic [PRIO_W-1:0] head_prio;

   assign head_id   = rd_ff[ENTRY_W-1:PRIO_W];
   assign head_prio = rd_ff[PRIO_W-1:0];

   always_comb begin
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      total_in   = total_ff;
      push_w     = 1'b0;
      pop_w      = 1'b0;
      blocked_in = 1'b0;
      woken_in   = 1'b0;
      wtask_in   = '0;
      wprio_in   = '0;
      preempt_in = 1'b0;
      fault_in   = FAULT_NONE;
      if (op_ff == OP_TAKE) begin
         priority if (count_ff != '0) begin
            count_in = count_ff - COUNT_BITS'(1);
         end else if (total_ff == TOTAL_FULL) begin
            fault_in = FAULT_FULL;
         end else begin
            push_w     = 1'b1;
            tail_in    = next_slot(tail_ff);
            total_in   = total_ff + TOTAL_W'(1);
            blocked_in = 1'b1;
         end
      end else begin
         priority if (count_ff == '0 && total_ff != '0) begin
            pop_w      = 1'b1;
            head_in    = next_slot(head_ff);
            total_in   = total_ff - TOTAL_W'(1);
            woken_in   = 1'b1;
            wtask_in   = head_id;
            wprio_in   = head_prio;
            preempt_in = (head_prio < prio_ff);
         end else if (count_ff == COUNT_MAX) begin
            fault_in = FAULT_SAT;
         end else begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   // queue store; head entry is read every cycle so it is ready at execute
   always_ff @(posedge clock) begin
      if (cmd.exec && push_w)
         mem[tail_ff] <= {id_ff, prio_ff};
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         id_ff   <= req_task_id;
         prio_ff <= clamp_prio(req_task_priority);
      end
      if (cmd.exec) begin
         blocked_ff <= blocked_in;
         woken_ff   <= woken_in;
         wtask_ff   <= wtask_in;
         wprio_ff   <= wprio_in;
         preempt_ff <= preempt_in;
         fault_ff   <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_BITS'(1);
         head_ff  <= '0;
         tail_ff  <= '0;
         total_ff <= '0;
      end else if (csr_we) begin
         count_ff <= COUNT_BITS'(csr_wdata);
         head_ff  <= '0;
         tail_ff  <= '0;
         total_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         total_ff <= total_in;
      end
   end

   assign rsp_blocked        = blocked_ff;
   assign rsp_woken_valid    = woken_ff;
   assign rsp_woken_task     = wtask_ff;
   assign rsp_woken_priority = wprio_ff;
   assign rsp_preempt        = preempt_ff;
   assign rsp_fault          = fault_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_FULL)
      else $error("wait queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (head_ff != tail_ff) |-> (total_ff != '0) && (total_ff != TOTAL_FULL))
      else $error("queue pointers disagree with occupancy");

   a_push: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && push_w && !csr_we) |=>
         (total_ff == $past(total_ff) + TOTAL_W'(1)) && (count_ff == '0))
      else $error("blocking take did not grow queue");

   a_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && pop_w && !csr_we) |=>
         (total_ff == $past(total_ff) - TOTAL_W'(1)) && $stable(count_ff))
      else $error("wake did not shrink queue or touched count");

endmodule

// ===== test/tb_counting_semaphore_wait_queue.sv =====
// Testbench for the counting semaphore wait queue: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_counting_semaphore_wait_queue;
   import csem_pkg::*;

   localparam int WAIT_DEPTH = 16;
   localparam int PRIORITY_LEVELS = 32;
   localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(PRIORITY_LEVELS - 1);
   localparam logic [CSR_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam int RESULT_LATENCY = 8;

   typedef struct packed {
      logic              op;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } sem_req_type;

   typedef struct packed {
      logic               blocked;
      logic               woken_valid;
      logic [ID_W-1:0]    woken_task;
      logic [PRIO_W-1:0]  woken_priority;
      logic               preempt;
      logic [FAULT_W-1:0] fault;
   } sem_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_op = OP_TAKE;
   logic [ID_W-1:0]    req_task_id = '0;
   logic [PRIO_W-1:0]  req_task_priority = '0;
   logic               rsp_valid;
   logic               rsp_blocked;
   logic               rsp_woken_valid;
   logic [ID_W-1:0]    rsp_woken_task;
   logic [PRIO_W-1:0]  rsp_woken_priority;
   logic               rsp_preempt;
   logic [FAULT_W-1:0] rsp_fault;
   logic               csr_we = 1'b0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   counting_semaphore_wait_queue u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_task_id        (req_task_id),
      .req_task_priority  (req_task_priority),
      .rsp_valid          (rsp_valid),
      .rsp_blocked        (rsp_blocked),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_task     (rsp_woken_task),
      .rsp_woken_priority (rsp_woken_priority),
      .rsp_preempt        (rsp_preempt),
      .rsp_fault          (rsp_fault),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted semaphore state
   logic [CSR_W-1:0]  tokens;
   logic [ID_W-1:0]   waiter_id [WAIT_DEPTH];
   logic [PRIO_W-1:0] waiter_prio [WAIT_DEPTH];
   int                wq_head;
   int                wq_tail;
   int                wq_count;

   sem_req_type request_queue[$];
   sem_rsp_type predicted_results[$];
   sem_req_type cur_req;
   int          sender_idle_pct = 0;
   int          mismatches = 0;

   task automatic reload_semaphore(input logic [CSR_W-1:0] count);
      tokens   = count;
      wq_head  = 0;
      wq_tail  = 0;
      wq_count = 0;
   endtask

   task automatic semaphore_step(input sem_req_type r, output sem_rsp_type res);
      logic [PRIO_W-1:0] p;
      res = '0;
      p = (r.prio > PRIO_TOP) ? PRIO_TOP : r.prio;
      if (r.op == OP_TAKE) begin
         if (tokens != 0) begin
            tokens = tokens - CSR_W'(1);
         end else if (wq_count >= WAIT_DEPTH) begin
            res.fault = FAULT_FULL;
         end else begin
            waiter_id[wq_tail]   = r.id;
            waiter_prio[wq_tail] = p;
            wq_tail = (wq_tail == WAIT_DEPTH - 1) ? 0 : wq_tail + 1;
            wq_count++;
            res.blocked = 1'b1;
         end
      end else begin
         if (tokens == 0 && wq_count != 0) begin
            res.woken_valid    = 1'b1;
            res.woken_task     = waiter_id[wq_head];
            res.woken_priority = waiter_prio[wq_head];
            res.preempt        = (waiter_prio[wq_head] < p);
            wq_head = (wq_head == WAIT_DEPTH - 1) ? 0 : wq_head + 1;
            wq_count--;
         end else if (tokens == COUNT_MAX) begin
            res.fault = FAULT_SAT;
         end else begin
            tokens = tokens + CSR_W'(1);
         end
      end
   endtask

   // driver: one word presented at a time, held until busy is low
   always @(posedge clock) begin
      sem_rsp_type res;
      logic        next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            semaphore_step(cur_req, res);
            predicted_results.push_back(res);
            next_start = 1'b0;
         end
         if (!next_start && request_queue.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            cur_req = request_queue.pop_front();
            req_op            <= cur_req.op;
            req_task_id       <= cur_req.id;
            req_task_priority <= cur_req.prio;
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   // monitor
   always @(posedge clock) begin
      sem_rsp_type act;
      sem_rsp_type exp;
      if (!reset && rsp_valid) begin
         act = '{rsp_blocked, rsp_woken_valid, rsp_woken_task, rsp_woken_priority,
                 rsp_preempt, rsp_fault};
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"unexpected result word: blocked=%0d woken=%0d task=%0d",
                         " prio=%0d preempt=%0d fault=%0d"},
                        act.blocked, act.woken_valid, act.woken_task, act.woken_priority,
                        act.preempt, act.fault);
         end else begin
            exp = predicted_results.pop_front();
            if (act.blocked !== exp.blocked || act.woken_valid !== exp.woken_valid ||
                act.woken_task !== exp.woken_task ||
                act.woken_priority !== exp.woken_priority ||
                act.preempt !== exp.preempt || act.fault !== exp.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch at %0t: exp blocked=%0d woken=%0d task=%0d",
                            " prio=%0d preempt=%0d fault=%0d, got blocked=%0d",
                            " woken=%0d task=%0d prio=%0d preempt=%0d fault=%0d"},
                           $realtime, exp.blocked, exp.woken_valid, exp.woken_task,
                           exp.woken_priority, exp.preempt, exp.fault,
                           act.blocked, act.woken_valid, act.woken_task,
                           act.woken_priority, act.preempt, act.fault);
            end
         end
      end
   end

   task automatic add_word(input logic op, input int id, input int prio);
      sem_req_type r;
      r.op   = op;
      r.id   = id[ID_W-1:0];
      r.prio = prio[PRIO_W-1:0];
      request_queue.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (request_queue.size() != 0 || start || predicted_results.size() != 0);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic write_initial_count(input logic [CSR_W-1:0] count);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      reload_semaphore(count);
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= CSR_W'($urandom_range(0, 65535));
   endtask

   // bursts of takes and gives fill and drain the wait queue; some single noise words
   task automatic add_random_words(input int n);
      int   made;
      int   burst;
      logic op;
      made = 0;
      op   = OP_TAKE;
      while (made < n) begin
         if ($urandom_range(0, 4) == 0) begin
            add_word(logic'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom_range(0, 31));
            made++;
         end else begin
            burst = $urandom_range(1, 20);
            repeat (burst)
               add_word(op, $urandom_range(0, 15), $urandom_range(0, 31));
            made += burst;
            op = ~op;
         end
      end
   endtask

   initial begin
      logic [CSR_W-1:0] counts [8];
      reload_semaphore(16'd1);
      counts = '{16'd0, 16'd3, COUNT_MAX, 16'd1, 16'd2, 16'hFFFE, 16'd0, 16'd5};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset count of one: take it, fill the wait queue, overflow it, then wake
      add_word(OP_TAKE, 0, 5);
      for (int i = 1; i <= WAIT_DEPTH; i++)
         add_word(OP_TAKE, i % 16, (i == 1) ? 0 : (i == 2) ? 31 : i);
      add_word(OP_TAKE, 9, 9);
      add_word(OP_GIVE, 7, 31);
      add_word(OP_GIVE, 8, 0);
      add_word(OP_GIVE, 10, 3);

      // saturation at the top of the count
      write_initial_count(COUNT_MAX);
      add_word(OP_GIVE, 15, 31);
      add_word(OP_TAKE, 1, 0);
      add_word(OP_GIVE, 2, 16);
      add_word(OP_GIVE, 3, 1);

      for (int ph = 0; ph < 8; ph++) begin
         write_initial_count((ph == 7) ? CSR_W'($urandom_range(0, 65535)) : counts[ph]);
         case (ph % 4)
            1: sender_idle_pct = 53;
            3: sender_idle_pct = 31;
            default: sender_idle_pct = 0;
         endcase
         add_random_words(60);
      end

      wait_idle();
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/csem_pkg.sv
design/csem_ctrl.sv
design/csem_dp.sv
design/counting_semaphore_wait_queue.sv
test/tb_counting_semaphore_wait_queue.sv
